FILE: rtl/core/lc3_pkg.sv
// Shared types, codes and helper functions for the LC-3 instruction step core.
package lc3_pkg;

   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_EXEC    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam logic [1:0] CC_NEG  = 2'd0;
   localparam logic [1:0] CC_ZERO = 2'd1;
   localparam logic [1:0] CC_POS  = 2'd2;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [2:0] LINK_REG = 3'd7;

   localparam logic [15:0] START_RESET = 16'h3000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POST,
      ST_FETCH,
      ST_EXEC,
      ST_MEM1,
      ST_MEM2
   } lc3_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] address;
      logic [15:0] data;
   } lc3_req_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [15:0] instr_word;
      logic [1:0]  cond_code;
      logic        halted;
      logic        dest_written;
      logic [2:0]  dest_reg;
      logic [15:0] dest_value;
      logic        mem_written;
   } lc3_rsp_type;

   typedef struct packed {
      logic        halt;
      logic        load;
      logic        ldi;
      logic        sti;
      logic        store;
      logic        dest_we;
      logic        set_cc;
      logic [2:0]  dest_reg;
      logic [15:0] value;
      logic [15:0] pc_next;
      logic [15:0] mem_addr;
   } lc3_dec_type;

   function automatic logic [15:0] sext5(input logic [4:0] v);
      return {{11{v[4]}}, v};
   endfunction

   function automatic logic [15:0] sext6(input logic [5:0] v);
      return {{10{v[5]}}, v};
   endfunction

   function automatic logic [15:0] sext9(input logic [8:0] v);
      return {{7{v[8]}}, v};
   endfunction

   function automatic logic [15:0] sext11(input logic [10:0] v);
      return {{5{v[10]}}, v};
   endfunction

   function automatic logic [1:0] cc_of(input logic [15:0] v);
      logic [1:0] cc;
      if (v[15]) begin
         cc = CC_NEG;
      end else if (v == 16'h0000) begin
         cc = CC_ZERO;
      end else begin
         cc = CC_POS;
      end
      return cc;
   endfunction

endpackage

FILE: rtl/core/lc3_dec.sv
// Instruction decode and datapath for one LC-3 instruction.
module lc3_dec (
   input  logic [15:0]         ir,
   input  logic [15:0]         pc,
   input  logic [15:0]         ra,
   input  logic [15:0]         rb,
   input  logic [1:0]          cc,
   output lc3_pkg::lc3_dec_type dec
);
   import lc3_pkg::*;

   logic [3:0]  op;
   logic [15:0] pc_off9;
   logic [15:0] ra_off6;
   logic [15:0] src2;
   logic        taken;

   assign op      = ir[15:12];
   assign pc_off9 = pc + sext9(ir[8:0]);
   assign ra_off6 = ra + sext6(ir[5:0]);
   assign src2    = ir[5] ? sext5(ir[4:0]) : rb;
   assign taken   = (ir[11] && (cc == CC_NEG)) || (ir[10] && (cc == CC_ZERO)) ||
                    (ir[9] && (cc == CC_POS));

   always_comb begin
      dec          = '0;
      dec.halt     = (ir == 16'h0000) || (op == OP_TRAP);
      dec.dest_reg = ir[11:9];
      dec.pc_next  = pc;
      dec.mem_addr = ((op == OP_LDR) || (op == OP_STR)) ? ra_off6 : pc_off9;
      unique case (op)
         OP_BR: begin
            if (taken) begin
               dec.pc_next = pc_off9;
            end
         end
         OP_ADD: begin
            dec.dest_we = 1'b1;
            dec.set_cc  = 1'b1;
            dec.value   = ra + src2;
         end
         OP_AND: begin
            dec.dest_we = 1'b1;
            dec.set_cc  = 1'b1;
            dec.value   = ra & src2;
         end
         OP_NOT: begin
            dec.dest_we = 1'b1;
            dec.set_cc  = 1'b1;
            dec.value   = ~ra;
         end
         OP_LEA: begin
            dec.dest_we = 1'b1;
            dec.set_cc  = 1'b1;
            dec.value   = pc_off9;
         end
         OP_JSR: begin
            dec.dest_we  = 1'b1;
            dec.dest_reg = LINK_REG;
            dec.value    = pc;
            dec.pc_next  = ir[11] ? (pc + sext11(ir[10:0])) : ra;
         end
         OP_JMP: begin
            dec.pc_next = ra;
         end
         OP_LD, OP_LDR: begin
            dec.load = 1'b1;
         end
         OP_LDI: begin
            dec.ldi = 1'b1;
         end
         OP_ST, OP_STR: begin
            dec.store = 1'b1;
         end
         OP_STI: begin
            dec.sti = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/lc3_instruction_step.sv
// LC-3 core top level: request sequencer, main memory and register file.
// Each request returns exactly one response. A memory write, a restart or an ignored
// request goes through ST_POST to the response register; an instruction goes through
// ST_FETCH and ST_EXEC, then LD, LDR, STI and LDI ST_MEM1 and LDI ST_MEM2, since the
// single-port main memory serves the fetch and every data access in turn. The next request is
// accepted once the previous one has reached the response register, which holds it
// until taken. No clearing pass: main memory is undefined until written, and the
// register file reads as zero until each register is first written.
module lc3_instruction_step #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lc3_pkg::lc3_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lc3_pkg::lc3_rsp_type rsp_payload
);
   import lc3_pkg::*;

   localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;

   lc3_state_type state_ff, state_in;

   logic [15:0] start_ff;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] ir_ff, ir_in;
   logic [1:0]  cc_ff, cc_in;
   logic        halt_ff, halt_in;

   logic [15:0] main_mem_ff [MEM_WORDS];
   logic [15:0] mem_rdata_ff;
   logic        mem_en;
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [15:0] mem_wdata;

   logic [15:0] rf_ff [8];
   logic [7:0]  rf_vld_ff;
   logic [15:0] ra_ff, rb_ff;
   logic        ra_vld_ff, rb_vld_ff;
   logic        rf_re;
   logic        rf_we;
   logic [2:0]  rf_waddr;
   logic [15:0] rf_wdata;
   logic [2:0]  ra_addr, rb_addr;
   logic [15:0] ra, rb;
   logic [3:0]  fetch_op;

   logic        rsp_valid_ff, rsp_valid_in;
   lc3_rsp_type rsp_ff, rsp_in;
   logic        rsp_load;
   logic        out_free;
   logic        accept;

   logic [15:0] word;
   logic        dw;
   logic [2:0]  dr;
   logic [15:0] dv;
   logic        mw;

   lc3_dec_type dec;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign ra = ra_vld_ff ? ra_ff : 16'h0000;
   assign rb = rb_vld_ff ? rb_ff : 16'h0000;

   assign fetch_op = mem_rdata_ff[15:12];
   assign ra_addr  = mem_rdata_ff[8:6];
   assign rb_addr  = (((fetch_op == OP_ADD) || (fetch_op == OP_AND)) && !mem_rdata_ff[5]) ?
                     mem_rdata_ff[2:0] : mem_rdata_ff[11:9];

   lc3_dec u_dec (
      .ir  (ir_ff),
      .pc  (pc_ff),
      .ra  (ra),
      .rb  (rb),
      .cc  (cc_ff),
      .dec (dec)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_payload.req_type == REQ_EXEC) && !halt_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!dec.halt && (dec.load || dec.ldi || dec.sti)) begin
               state_in = ST_MEM1;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MEM1: begin
            if (dec.ldi) begin
               state_in = ST_MEM2;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MEM2: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = pc_ff;
      mem_wdata = rb;
      rf_re     = 1'b0;
      rf_we     = 1'b0;
      rf_waddr  = dec.dest_reg;
      rf_wdata  = dec.value;
      pc_in     = pc_ff;
      ir_in     = ir_ff;
      cc_in     = cc_ff;
      halt_in   = halt_ff;
      rsp_load  = 1'b0;
      word      = 16'h0000;
      dw        = 1'b0;
      dr        = 3'd0;
      dv        = 16'h0000;
      mw        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.req_type)
                  REQ_WRITE: begin
                     mem_en    = 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = req_payload.address;
                     mem_wdata = req_payload.data;
                  end
                  REQ_RESTART: begin
                     pc_in   = start_ff;
                     halt_in = 1'b0;
                  end
                  REQ_EXEC: begin
                     if (!halt_ff) begin
                        mem_en = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POST: begin
            rsp_load = out_free;
         end
         ST_FETCH: begin
            ir_in = mem_rdata_ff;
            pc_in = pc_ff + 16'd1;
            rf_re = 1'b1;
         end
         ST_EXEC: begin
            word = ir_ff;
            if (dec.halt) begin
               if (out_free) begin
                  halt_in  = 1'b1;
                  rsp_load = 1'b1;
               end
            end else if (dec.load || dec.ldi || dec.sti) begin
               mem_en   = 1'b1;
               mem_addr = dec.mem_addr;
            end else if (dec.store) begin
               if (out_free) begin
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = dec.mem_addr;
                  mw       = 1'b1;
                  rsp_load = 1'b1;
               end
            end else if (out_free) begin
               pc_in    = dec.pc_next;
               rsp_load = 1'b1;
               if (dec.dest_we) begin
                  rf_we = 1'b1;
                  dw    = 1'b1;
                  dr    = dec.dest_reg;
                  dv    = dec.value;
               end
               if (dec.set_cc) begin
                  cc_in = cc_of(dec.value);
               end
            end
         end
         ST_MEM1: begin
            word = ir_ff;
            if (dec.ldi) begin
               mem_en   = 1'b1;
               mem_addr = mem_rdata_ff;
            end else if (dec.sti) begin
               if (out_free) begin
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = mem_rdata_ff;
                  mw       = 1'b1;
                  rsp_load = 1'b1;
               end
            end else if (out_free) begin
               rf_we    = 1'b1;
               rf_wdata = mem_rdata_ff;
               dw       = 1'b1;
               dr       = dec.dest_reg;
               dv       = mem_rdata_ff;
               cc_in    = cc_of(mem_rdata_ff);
               rsp_load = 1'b1;
            end
         end
         ST_MEM2: begin
            word = ir_ff;
            if (out_free) begin
               rf_we    = 1'b1;
               rf_wdata = mem_rdata_ff;
               dw       = 1'b1;
               dr       = dec.dest_reg;
               dv       = mem_rdata_ff;
               cc_in    = cc_of(mem_rdata_ff);
               rsp_load = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.pc           = pc_in;
      rsp_in.instr_word   = word;
      rsp_in.cond_code    = cc_in;
      rsp_in.halted       = halt_in;
      rsp_in.dest_written = dw;
      rsp_in.dest_reg     = dr;
      rsp_in.dest_value   = dv;
      rsp_in.mem_written  = mw;
      rsp_valid_in        = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= START_RESET;
         pc_ff        <= 16'h0000;
         ir_ff        <= 16'h0000;
         cc_ff        <= CC_ZERO;
         halt_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         ir_ff        <= ir_in;
         cc_ff        <= cc_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            main_mem_ff[mem_addr[MEM_ADDR_BITS-1:0]] <= mem_wdata;
         end else begin
            mem_rdata_ff <= main_mem_ff[mem_addr[MEM_ADDR_BITS-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[rf_waddr] <= rf_wdata;
      end
      if (rf_re) begin
         ra_ff     <= rf_ff[ra_addr];
         rb_ff     <= rf_ff[rb_addr];
         ra_vld_ff <= rf_vld_ff[ra_addr];
         rb_vld_ff <= rf_vld_ff[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten before it was taken");

   a_no_fetch_halted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> !halt_ff)
      else $error("fetch while the core is halted");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start");

   a_one_write_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(dw && mw))
      else $error("step wrote both a register and memory");
`endif

endmodule

FILE: dv/tb_lc3_instruction_step.sv
// Self-checking testbench for the LC-3 instruction step core: directed program, then random.
module tb_lc3_instruction_step;
   import lc3_pkg::*;

   localparam int ITEM_TARGET = 550;
   localparam int PHASE_ITEMS = 70;
   localparam int IDLE_PCT = 35;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      lc3_req_type rq;
      bit          typed;
      lc3_rsp_type rsp;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lc3_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lc3_rsp_type rsp_payload;

   logic [15:0] shadow_mem [0:65535];
   bit          shadow_written [0:65535];
   logic [15:0] shadow_regs [0:7];
   logic [15:0] shadow_pc = 16'h0000;
   logic [1:0]  shadow_cc = CC_ZERO;
   logic        shadow_halt = 1'b1;
   logic [15:0] shadow_origin = START_RESET;

   lc3_rsp_type    pending_steps [$];
   script_row_type script [$];
   int          error_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   lc3_instruction_step #(
      .MEM_ADDR_BITS(16)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic lc3_req_type make_req(input logic [1:0] kind, input logic [15:0] addr,
                                            input logic [15:0] value);
      lc3_req_type rq;
      rq.req_type = kind;
      rq.address = addr;
      rq.data = value;
      return rq;
   endfunction

   function automatic logic [15:0] random_word();
      logic [15:0] word;
      case ($urandom_range(0, 7))
         0: word = 16'h0000;
         1: word = 16'hFFFF;
         2: word = 16'h8000;
         default: word = 16'($urandom);
      endcase
      return word;
   endfunction

   function automatic logic [15:0] random_instr();
      logic [15:0] word;
      word = 16'($urandom);
      if ($urandom_range(0, 99) < 3) word = 16'h0000;
      return word;
   endfunction

   function automatic void store_word(input logic [15:0] addr, input logic [15:0] value);
      shadow_mem[addr] = value;
      shadow_written[addr] = 1'b1;
   endfunction

   function automatic lc3_rsp_type execute_step(input lc3_req_type rq);
      lc3_rsp_type rs;
      logic [15:0] ir, npc, opnd, target, imm5, off6, off9, off11;
      logic [2:0]  rd, rb;
      logic        taken;
      rs = '0;
      case (rq.req_type)
         REQ_WRITE: store_word(rq.address, rq.data);
         REQ_RESTART: begin
            shadow_pc = shadow_origin;
            shadow_halt = 1'b0;
         end
         REQ_EXEC: begin
            if (!shadow_halt) begin
               ir = shadow_mem[shadow_pc];
               shadow_pc = shadow_pc + 16'd1;
               npc = shadow_pc;
               rd = ir[11:9];
               rb = ir[8:6];
               imm5 = {{11{ir[4]}}, ir[4:0]};
               off6 = {{10{ir[5]}}, ir[5:0]};
               off9 = {{7{ir[8]}}, ir[8:0]};
               off11 = {{5{ir[10]}}, ir[10:0]};
               rs.instr_word = ir;
               if (ir == 16'h0000 || ir[15:12] == OP_TRAP) begin
                  shadow_halt = 1'b1;
               end else begin
                  case (ir[15:12])
                     OP_BR: begin
                        taken = (ir[11] && shadow_cc == CC_NEG) ||
                                (ir[10] && shadow_cc == CC_ZERO) ||
                                (ir[9] && shadow_cc == CC_POS);
                        if (taken) shadow_pc = npc + off9;
                     end
                     OP_ADD, OP_AND: begin
                        opnd = ir[5] ? imm5 : shadow_regs[ir[2:0]];
                        rs.dest_value = (ir[15:12] == OP_ADD) ? shadow_regs[rb] + opnd
                                                              : shadow_regs[rb] & opnd;
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     OP_LD: begin
                        rs.dest_value = shadow_mem[16'(npc + off9)];
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     OP_ST: begin
                        store_word(npc + off9, shadow_regs[rd]);
                        rs.mem_written = 1'b1;
                     end
                     OP_JSR: begin
                        target = ir[11] ? npc + off11 : shadow_regs[rb];
                        rs.dest_value = npc;
                        rs.dest_written = 1'b1;
                        rs.dest_reg = LINK_REG;
                        shadow_pc = target;
                     end
                     OP_LDR: begin
                        rs.dest_value = shadow_mem[16'(shadow_regs[rb] + off6)];
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     OP_STR: begin
                        store_word(shadow_regs[rb] + off6, shadow_regs[rd]);
                        rs.mem_written = 1'b1;
                     end
                     OP_NOT: begin
                        rs.dest_value = ~shadow_regs[rb];
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     OP_LDI: begin
                        rs.dest_value = shadow_mem[shadow_mem[16'(npc + off9)]];
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     OP_STI: begin
                        store_word(shadow_mem[16'(npc + off9)], shadow_regs[rd]);
                        rs.mem_written = 1'b1;
                     end
                     OP_JMP: shadow_pc = shadow_regs[rb];
                     OP_LEA: begin
                        rs.dest_value = npc + off9;
                        rs.dest_written = 1'b1;
                        rs.dest_reg = rd;
                     end
                     default: ;
                  endcase
                  if (rs.dest_written) begin
                     shadow_regs[rs.dest_reg] = rs.dest_value;
                     if (ir[15:12] != OP_JSR) begin
                        if (rs.dest_value[15]) begin
                           shadow_cc = CC_NEG;
                        end else if (rs.dest_value == 16'h0000) begin
                           shadow_cc = CC_ZERO;
                        end else begin
                           shadow_cc = CC_POS;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      rs.pc = shadow_pc;
      rs.cond_code = shadow_cc;
      rs.halted = shadow_halt;
      return rs;
   endfunction

   function automatic void add_step(input logic [1:0] kind, input logic [15:0] addr,
                                    input logic [15:0] value);
      script_row_type row;
      row.rq = make_req(kind, addr, value);
      row.typed = 1'b0;
      row.rsp = '0;
      script.push_back(row);
   endfunction

   function automatic void add_checked(input logic [1:0] kind, input logic [15:0] addr,
                                       input logic [15:0] value, input logic [15:0] pc,
                                       input logic halted);
      script_row_type row;
      row.rq = make_req(kind, addr, value);
      row.typed = 1'b1;
      row.rsp = '0;
      row.rsp.pc = pc;
      row.rsp.cond_code = CC_ZERO;
      row.rsp.halted = halted;
      script.push_back(row);
   endfunction

   task automatic issue_request(input lc3_req_type rq, input bit typed,
                                input lc3_rsp_type fixed);
      lc3_rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predicted = execute_step(rq);
      pending_steps.push_back(typed ? fixed : predicted);
      req_valid <= 1'b1;
      req_payload <= rq;
      items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [15:0] value);
      issue_request(make_req(kind, addr, value), 1'b0, '0);
   endtask

   // fill every word the next instruction reads before executing it
   task automatic run_instruction();
      logic [15:0] ir, ptr;
      if (!shadow_halt) begin
         if (!shadow_written[shadow_pc]) send_request(REQ_WRITE, shadow_pc, random_instr());
         ir = shadow_mem[shadow_pc];
         ptr = shadow_pc + 16'd1 + {{7{ir[8]}}, ir[8:0]};
         if (ir[15:12] == OP_LDR) ptr = shadow_regs[ir[8:6]] + {{10{ir[5]}}, ir[5:0]};
         if (ir[15:12] inside {OP_LD, OP_LDR, OP_LDI, OP_STI} && !shadow_written[ptr]) begin
            send_request(REQ_WRITE, ptr, random_word());
         end
         if (ir[15:12] == OP_LDI && !shadow_written[shadow_mem[ptr]]) begin
            send_request(REQ_WRITE, shadow_mem[ptr], random_word());
         end
      end
      send_request(REQ_EXEC, 16'($urandom), 16'($urandom));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= 100) begin
         $display("MISMATCH %s: got %h expected %h at cycle %0d", field, got, want,
                  cycle_count);
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   always @(posedge clock) begin : watch_rsp
      lc3_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_steps.size() == 0) begin
            report_mismatch("unexpected response pc", rsp_payload.pc, 16'h0000);
         end else begin
            want = pending_steps.pop_front();
            check_field("pc", rsp_payload.pc, want.pc);
            check_field("instr_word", rsp_payload.instr_word, want.instr_word);
            check_field("cond_code", 16'(rsp_payload.cond_code), 16'(want.cond_code));
            check_field("halted", 16'(rsp_payload.halted), 16'(want.halted));
            check_field("dest_written", 16'(rsp_payload.dest_written),
                        16'(want.dest_written));
            check_field("dest_reg", 16'(rsp_payload.dest_reg), 16'(want.dest_reg));
            check_field("dest_value", rsp_payload.dest_value, want.dest_value);
            check_field("mem_written", 16'(rsp_payload.mem_written),
                        16'(want.mem_written));
         end
      end
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int          phase;
      int          next_phase;
      int          pick;
      logic [15:0] origin;
      for (int i = 0; i < 8; i++) shadow_regs[i] = 16'h0000;

      add_checked(REQ_EXEC, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      add_checked(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
      add_step(REQ_WRITE, 16'h3000, {OP_ADD, 3'd1, 3'd1, 1'b1, 5'b10000});
      add_step(REQ_WRITE, 16'h3001, {OP_ADD, 3'd2, 3'd2, 1'b1, 5'b01111});
      add_step(REQ_WRITE, 16'h3002, {OP_ADD, 3'd3, 3'd1, 3'b000, 3'd2});
      add_step(REQ_WRITE, 16'h3003, {OP_AND, 3'd4, 3'd3, 1'b1, 5'b00000});
      add_step(REQ_WRITE, 16'h3004, {OP_LEA, 3'd7, 9'h0FF});
      add_step(REQ_WRITE, 16'h3005, {OP_JSR, 1'b0, 2'b00, 3'd7, 6'd0});
      add_step(REQ_WRITE, 16'h3104, {OP_TRAP, 4'h0, 8'hFF});
      add_step(REQ_WRITE, 16'hFFFF, 16'h0000);
      add_step(REQ_WRITE, 16'h0000, 16'hFFFF);
      add_checked(REQ_RESTART, 16'h0000, 16'h0000, START_RESET, 1'b0);
      repeat (7) add_step(REQ_EXEC, 16'h0000, 16'h0000);
      add_step(REQ_EXEC, 16'hFFFF, 16'hFFFF);
      add_step(REQ_RESTART, 16'h5555, 16'hAAAA);
      add_step(REQ_EXEC, 16'h0000, 16'h0000);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) issue_request(script[i].rq, script[i].typed, script[i].rsp);

      phase = 0;
      next_phase = items_sent;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_phase) begin
            drain_responses();
            case (phase)
               0: origin = 16'hFFFF;
               1: origin = 16'h0000;
               default: origin = 16'($urandom);
            endcase
            csr_wr_en <= 1'b1;
            csr_wr_data <= origin;
            shadow_origin = origin;
            @(posedge clock);
            csr_wr_en <= 1'b0;
            steady = (phase == 3);
            phase++;
            next_phase = items_sent + PHASE_ITEMS;
         end
         pick = $urandom_range(0, 99);
         if (shadow_halt) begin
            if (pick < 70) begin
               send_request(REQ_RESTART, 16'($urandom), 16'($urandom));
            end else if (pick < 80) begin
               send_request(REQ_EXEC, 16'($urandom), 16'($urandom));
            end else if (pick < 90) begin
               send_request(REQ_WRITE, 16'($urandom), random_word());
            end else begin
               send_request(REQ_UNUSED, 16'($urandom), 16'($urandom));
            end
         end else begin
            if (pick < 85) begin
               run_instruction();
            end else if (pick < 90) begin
               send_request(REQ_RESTART, 16'($urandom), 16'($urandom));
            end else if (pick < 95) begin
               send_request(REQ_WRITE, 16'($urandom), random_word());
            end else begin
               send_request(REQ_UNUSED, 16'($urandom), 16'($urandom));
            end
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/lc3_pkg.sv
rtl/core/lc3_dec.sv
rtl/core/lc3_instruction_step.sv
dv/tb_lc3_instruction_step.sv
